// File: hdl/oets_pkg.sv
// ----------------------------------------------------------------------------
// oets_pkg
// Shared types and constants for the odd-even transposition sorter.
// ----------------------------------------------------------------------------
`default_nettype none

package oets_pkg;

  localparam int unsigned DATA_W = 32;

  typedef logic signed [DATA_W-1:0] data_t;

  typedef struct packed {
    logic  valid;
    data_t value;
  } cell_t;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_LOAD,
    CMD_SORT_LO,
    CMD_SORT_HI,
    CMD_SHIFT
  } cell_cmd_e;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SORT,
    ST_EMIT
  } state_e;

endpackage

`default_nettype wire

// File: hdl/oets_in_if.sv
// ----------------------------------------------------------------------------
// oets_in_if
// Input channel: one unsorted word per handshake, with an end-of-set mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface oets_in_if;
  import oets_pkg::*;

  logic  valid;
  logic  ready;
  data_t value;
  logic  last;

  modport source (output valid, output value, output last, input ready);
  modport sink (input valid, input value, input last, output ready);
endinterface

`default_nettype wire

// File: hdl/oets_out_if.sv
// ----------------------------------------------------------------------------
// oets_out_if
// Output channel: one sorted word per handshake, with run end and overflow.
// ----------------------------------------------------------------------------
`default_nettype none

interface oets_out_if;
  import oets_pkg::*;

  logic  valid;
  logic  ready;
  data_t sorted_value;
  logic  last_out;
  logic  overflow;

  modport source (output valid, output sorted_value, output last_out, output overflow,
                  input ready);
  modport sink (input valid, input sorted_value, input last_out, input overflow,
                output ready);
endinterface

`default_nettype wire

// File: hdl/oets_cell.sv
// ----------------------------------------------------------------------------
// oets_cell
// One sorter cell: holds a word, loads, compare-exchanges with a neighbor,
// or takes the word of its upper neighbor. Empty cells rank above all words.
// ----------------------------------------------------------------------------
`default_nettype none

module oets_cell
  import oets_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  cell_cmd_e  cmd_i,
  input  data_t      load_value_i,
  input  cell_t      left_i,
  input  cell_t      right_i,
  output cell_t      cell_o
);

  function automatic logic ranks_above(cell_t a, cell_t b);
    logic res;
    if (!a.valid) begin
      res = b.valid;
    end else begin
      res = b.valid && (a.value > b.value);
    end
    return res;
  endfunction

  logic  valid_q, valid_d;
  data_t value_q, value_d;
  cell_t self;

  assign self = '{valid: valid_q, value: value_q};

  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    unique case (cmd_i)
      CMD_HOLD: begin
      end
      CMD_LOAD: begin
        valid_d = 1'b1;
        value_d = load_value_i;
      end
      CMD_SORT_LO: begin
        if (ranks_above(self, right_i)) begin
          valid_d = right_i.valid;
          value_d = right_i.value;
        end
      end
      CMD_SORT_HI: begin
        if (ranks_above(left_i, self)) begin
          valid_d = left_i.valid;
          value_d = left_i.value;
        end
      end
      CMD_SHIFT: begin
        valid_d = right_i.valid;
        value_d = right_i.value;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign cell_o = self;

endmodule

`default_nettype wire

// File: hdl/odd_even_transposition_sorter.sv
// ----------------------------------------------------------------------------
// odd_even_transposition_sorter
// Collects a set of signed words, sorts them in a row of compare-exchange
// cells and returns them in ascending order.
// ----------------------------------------------------------------------------
// in_i takes one word per handshake into cell number "count"; the word with
// last set closes the set. Words that arrive with all MAX_ITEMS cells full
// are dropped and the overflow flag is set for that run. The sort then runs
// one odd or even phase per cycle across the whole row, and the number of
// held words sets the phase count; the sorted words are then emitted. in_i
// is ready only while collecting.
// out_o shows cell 0 directly; each accepted word shifts the row down by one.
// last_out marks the final word and overflow is set on every word of a run
// that lost input. A stalled receiver simply holds the row. Reset empties
// the row and returns to collecting; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module odd_even_transposition_sorter
  import oets_pkg::*;
#(
  parameter int unsigned MAX_ITEMS = 32
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  oets_in_if.sink     in_i,
  oets_out_if.source  out_o
);

  localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] phase_q, phase_d;
  logic             ovf_q, ovf_d;

  logic in_fire, out_fire, full;
  logic in_rdy, out_vld;

  cell_t     cells [MAX_ITEMS];
  cell_cmd_e cmds  [MAX_ITEMS];

  assign full     = (count_q == CNT_W'(MAX_ITEMS));
  assign in_fire  = in_i.valid && in_rdy;
  assign out_fire = out_vld && out_o.ready;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: if (in_fire && in_i.last) state_d = ST_SORT;
      ST_SORT: if (phase_q == count_q - CNT_W'(1)) state_d = ST_EMIT;
      ST_EMIT: if (out_fire && count_q == CNT_W'(1)) state_d = ST_LOAD;
      default: state_d = ST_LOAD;
    endcase
  end

  // outputs and counters
  always_comb begin
    in_rdy  = 1'b0;
    out_vld = 1'b0;
    count_d = count_q;
    phase_d = phase_q;
    ovf_d   = ovf_q;
    unique case (state_q)
      ST_LOAD: begin
        in_rdy  = 1'b1;
        phase_d = '0;
        if (in_fire) begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            count_d = count_q + CNT_W'(1);
          end
        end
      end
      ST_SORT: begin
        phase_d = phase_q + CNT_W'(1);
      end
      ST_EMIT: begin
        out_vld = 1'b1;
        if (out_fire) begin
          count_d = count_q - CNT_W'(1);
          if (count_q == CNT_W'(1)) ovf_d = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      count_q <= '0;
      phase_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      phase_q <= phase_d;
      ovf_q   <= ovf_d;
    end
  end

  // cell row
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    localparam logic CELL_ODD = ((i % 2) == 1);
    cell_t left_n, right_n;

    if (i == 0) begin : g_left_edge
      assign left_n = '0;
    end else begin : g_left
      assign left_n = cells[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_right_edge
      assign right_n = '0;
    end else begin : g_right
      assign right_n = cells[i+1];
    end

    always_comb begin
      cmds[i] = CMD_HOLD;
      unique case (state_q)
        ST_LOAD: begin
          if (in_fire && !full && count_q == CNT_W'(i)) cmds[i] = CMD_LOAD;
        end
        ST_SORT: begin
          if (CELL_ODD == phase_q[0]) begin
            if (i < MAX_ITEMS - 1) cmds[i] = CMD_SORT_LO;
          end else begin
            if (i > 0) cmds[i] = CMD_SORT_HI;
          end
        end
        ST_EMIT: begin
          if (out_fire) cmds[i] = CMD_SHIFT;
        end
        default: begin
        end
      endcase
    end

    oets_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmds[i]),
      .load_value_i(in_i.value),
      .left_i      (left_n),
      .right_i     (right_n),
      .cell_o      (cells[i])
    );
  end

  assign in_i.ready         = in_rdy;
  assign out_o.valid        = out_vld;
  assign out_o.sorted_value = cells[0].value;
  assign out_o.last_out     = (count_q == CNT_W'(1));
  assign out_o.overflow     = ovf_q;

`ifndef ASSERT_OFF
  a_out_from_full_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld |-> cells[0].valid)
    else $error("output word taken from an empty cell");

  a_last_matches_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld && out_o.last_out) |-> !cells[1].valid)
    else $error("last word flagged while more words are held");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_ITEMS))
    else $error("word count beyond capacity");

  a_back_to_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && out_o.last_out) |=> (in_rdy && count_q == '0 && !ovf_q))
    else $error("run end did not return to collecting");

  a_sides_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_rdy && out_vld))
    else $error("input and output active together");
`endif

endmodule

`default_nettype wire
